// ----- rtl/chbh_pkg.sv -----
// ----------------------------------------------------------------------------
// chbh_pkg
// Shared types and constants of the chained-bucket hash table unit.
// ----------------------------------------------------------------------------
package chbh_pkg;

   localparam int KEY_BITS        = 31;
   localparam int VALUE_PORT_BITS = 64;

   // remainder unit: digits per cycle over the key padded to a whole number of digits
   localparam int MOD_BITS     = 4;
   localparam int KEY_PAD_BITS = 32;
   localparam int MOD_STEPS    = KEY_PAD_BITS / MOD_BITS;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_MISS = 2'd1,
      STAT_FULL = 2'd2
   } status_type;

   typedef struct packed {
      logic                       cmd;
      logic [KEY_BITS-1:0]        key;
      logic [VALUE_PORT_BITS-1:0] value;
   } req_type;

   typedef struct packed {
      status_type                 status;
      logic [VALUE_PORT_BITS-1:0] found_value;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic       clr_step;
      logic       load;
      logic       head_rd;
      logic       take_head;
      logic       meta_rd;
      logic       follow;
      logic       slot_clr;
      logic       slot_rd;
      logic       slot_inc;
      logic       ins_slot;
      logic       link;
      logic       alloc;
      logic       alloc_head;
      logic       rsp_go;
      logic       rsp_hit;
      status_type rsp_status;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clr_done;
      logic mod_done;
      logic is_search;
      logic head_valid;
      logic next_valid;
      logic block_full;
      logic pool_full;
      logic key_match;
      logic slot_last;
   } dp_stat_type;

endpackage

// ----- rtl/chbh_mod.sv -----
// ----------------------------------------------------------------------------
// chbh_mod
// Key remainder modulo the bucket count, a few key bits per cycle.
// ----------------------------------------------------------------------------
module chbh_mod #(
   parameter int  BUCKETS = 16,
   localparam int HW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [chbh_pkg::KEY_BITS-1:0]    key,
   output logic                             done,
   output logic [HW-1:0]                    rem
);

   localparam int PB = chbh_pkg::KEY_PAD_BITS;
   localparam int DB = chbh_pkg::MOD_BITS;
   localparam int CW = (chbh_pkg::MOD_STEPS > 1) ? $clog2(chbh_pkg::MOD_STEPS) : 1;
   localparam logic [HW:0] BUCKETS_W = (HW+1)'(BUCKETS);

   logic [HW-1:0] rem_ff, rem_in;
   logic [PB-1:0] sh_ff, sh_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in;
   logic          done_ff, done_in;

   always_comb begin
      logic [HW:0]   t;
      logic [HW-1:0] r;
      logic [PB-1:0] s;
      r       = rem_ff;
      s       = sh_ff;
      t       = '0;
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         sh_in  = PB'(key);
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         // restoring remainder, one compare and subtract per key bit
         for (int i = 0; i < DB; i++) begin
            t = {r, s[PB-1]};
            s = s << 1;
            if (t >= BUCKETS_W) begin
               t = t - BUCKETS_W;
            end
            r = t[HW-1:0];
         end
         rem_in = r;
         sh_in  = s;
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(chbh_pkg::MOD_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

// ----- rtl/chbh_dp.sv -----
// ----------------------------------------------------------------------------
// chbh_dp
// Datapath: bucket heads, block pool memories, walk registers and result.
// ----------------------------------------------------------------------------
module chbh_dp #(
   parameter int BUCKETS         = 16,
   parameter int SLOTS_PER_BLOCK = 4,
   parameter int POOL_BLOCKS     = 256,
   parameter int VALUE_BITS      = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  chbh_pkg::req_type      req_data,
   input  chbh_pkg::ctrl_cmd_type cmd,
   output chbh_pkg::dp_stat_type  stat,
   output logic                   rsp_strobe,
   output chbh_pkg::rsp_type      rsp_data
);

   localparam int HW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int BW  = (POOL_BLOCKS > 1) ? $clog2(POOL_BLOCKS) : 1;
   localparam int UW  = $clog2(POOL_BLOCKS + 1);
   localparam int SW  = (SLOTS_PER_BLOCK > 1) ? $clog2(SLOTS_PER_BLOCK) : 1;
   localparam int FW  = $clog2(SLOTS_PER_BLOCK + 1);
   localparam int MW  = FW + 1 + BW;
   localparam int SAW = BW + SW;
   localparam int SLOT_DEPTH = POOL_BLOCKS * (1 << SW);
   localparam int KB  = chbh_pkg::KEY_BITS;
   localparam int VPB = chbh_pkg::VALUE_PORT_BITS;

   // memories
   logic [BW:0]           head_mem [BUCKETS];
   logic [MW-1:0]         meta_mem [POOL_BLOCKS];
   logic [KB-1:0]         key_mem  [SLOT_DEPTH];
   logic [VALUE_BITS-1:0] val_mem  [SLOT_DEPTH];

   logic [BW:0]           head_rd_ff;
   logic [MW-1:0]         meta_rd_ff;
   logic [KB-1:0]         key_rd_ff;
   logic [VALUE_BITS-1:0] val_rd_ff;

   chbh_pkg::req_type     req_ff;
   logic [BW-1:0]         cur_ff;
   logic [SW-1:0]         slot_ff;
   logic [UW-1:0]         used_ff;
   logic [HW-1:0]         clr_idx_ff;
   logic                  rsp_strobe_ff;
   chbh_pkg::rsp_type     rsp_data_ff;

   logic [HW-1:0]         bucket;
   logic                  mod_done;
   logic [FW-1:0]         fill_rd;
   logic                  next_valid_rd;
   logic [BW-1:0]         next_rd;
   logic [BW-1:0]         used_blk;

   logic                  head_we;
   logic [HW-1:0]         head_wa;
   logic [BW:0]           head_wd;
   logic                  meta_we;
   logic [BW-1:0]         meta_wa;
   logic [MW-1:0]         meta_wd;
   logic                  slot_we;
   logic [SAW-1:0]        slot_wa;

   chbh_mod #(.BUCKETS(BUCKETS)) u_mod (
      .clock (clock),
      .reset (reset),
      .start (cmd.load),
      .key   (req_data.key),
      .done  (mod_done),
      .rem   (bucket)
   );

   assign fill_rd       = meta_rd_ff[MW-1 -: FW];
   assign next_valid_rd = meta_rd_ff[BW];
   assign next_rd       = meta_rd_ff[BW-1:0];
   assign used_blk      = used_ff[BW-1:0];

   // write port selection
   always_comb begin
      head_we = cmd.clr_step | cmd.alloc_head;
      head_wa = cmd.clr_step ? clr_idx_ff : bucket;
      head_wd = cmd.clr_step ? '0 : {1'b1, used_blk};

      meta_we = cmd.ins_slot | cmd.link | cmd.alloc;
      meta_wa = cmd.alloc ? used_blk : cur_ff;
      if (cmd.alloc) begin
         meta_wd = {FW'(1), 1'b0, BW'(0)};
      end else if (cmd.link) begin
         meta_wd = {fill_rd, 1'b1, used_blk};
      end else begin
         meta_wd = {fill_rd + FW'(1), 1'b0, next_rd};
      end

      slot_we = cmd.ins_slot | cmd.alloc;
      slot_wa = cmd.alloc ? {used_blk, SW'(0)} : {cur_ff, fill_rd[SW-1:0]};
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_wa] <= head_wd;
      end
      if (cmd.head_rd) begin
         head_rd_ff <= head_mem[bucket];
      end
   end

   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_wa] <= meta_wd;
      end
      if (cmd.meta_rd) begin
         meta_rd_ff <= meta_mem[cur_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         key_mem[slot_wa] <= req_ff.key;
         val_mem[slot_wa] <= req_ff.value[VALUE_BITS-1:0];
      end
      if (cmd.slot_rd) begin
         key_rd_ff <= key_mem[{cur_ff, slot_ff}];
         val_rd_ff <= val_mem[{cur_ff, slot_ff}];
      end
   end

   // walk registers and request hold
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.take_head) begin
         cur_ff <= head_rd_ff[BW-1:0];
      end else if (cmd.follow) begin
         cur_ff <= next_rd;
      end
      if (cmd.slot_clr) begin
         slot_ff <= '0;
      end else if (cmd.slot_inc) begin
         slot_ff <= slot_ff + SW'(1);
      end
      if (cmd.rsp_go) begin
         rsp_data_ff.status      <= cmd.rsp_status;
         rsp_data_ff.found_value <= cmd.rsp_hit ? VPB'(val_rd_ff) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff       <= '0;
         clr_idx_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (cmd.alloc) begin
            used_ff <= used_ff + UW'(1);
         end
         if (cmd.clr_step) begin
            clr_idx_ff <= clr_idx_ff + HW'(1);
         end
         rsp_strobe_ff <= cmd.rsp_go;
      end
   end

   always_comb begin
      stat.clr_done   = (clr_idx_ff == HW'(BUCKETS - 1));
      stat.mod_done   = mod_done;
      stat.is_search  = (req_ff.cmd == chbh_pkg::CMD_SEARCH);
      stat.head_valid = head_rd_ff[BW];
      stat.next_valid = next_valid_rd;
      stat.block_full = (fill_rd == FW'(SLOTS_PER_BLOCK));
      stat.pool_full  = (used_ff == UW'(POOL_BLOCKS));
      stat.key_match  = (key_rd_ff == req_ff.key);
      stat.slot_last  = ((FW'(slot_ff) + FW'(1)) >= fill_rd);
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// ----- rtl/chbh_ctrl.sv -----
// ----------------------------------------------------------------------------
// chbh_ctrl
// Controller: sequences hashing, chain walk, insertion and the result.
// ----------------------------------------------------------------------------
module chbh_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  chbh_pkg::dp_stat_type  stat,
   output chbh_pkg::ctrl_cmd_type cmd
);

   typedef enum logic [9:0] {
      ST_CLEAR    = 10'b00_0000_0001,
      ST_IDLE     = 10'b00_0000_0010,
      ST_HASH     = 10'b00_0000_0100,
      ST_HEAD_CHK = 10'b00_0000_1000,
      ST_META_RD  = 10'b00_0001_0000,
      ST_META_CHK = 10'b00_0010_0000,
      ST_ALLOC    = 10'b00_0100_0000,
      ST_SLOT_RD  = 10'b00_1000_0000,
      ST_SLOT_CHK = 10'b01_0000_0000,
      ST_SPARE    = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            if (stat.mod_done) begin
               cmd.head_rd = 1'b1;
               state_in    = ST_HEAD_CHK;
            end
         end
         ST_HEAD_CHK: begin
            if (stat.head_valid) begin
               cmd.take_head = 1'b1;
               state_in      = ST_META_RD;
            end else if (stat.is_search) begin
               cmd.rsp_go     = 1'b1;
               cmd.rsp_status = chbh_pkg::STAT_MISS;
               state_in       = ST_IDLE;
            end else if (stat.pool_full) begin
               cmd.rsp_go     = 1'b1;
               cmd.rsp_status = chbh_pkg::STAT_FULL;
               state_in       = ST_IDLE;
            end else begin
               // empty bucket: new block becomes the chain head
               cmd.alloc      = 1'b1;
               cmd.alloc_head = 1'b1;
               cmd.rsp_go     = 1'b1;
               cmd.rsp_status = chbh_pkg::STAT_OK;
               state_in       = ST_IDLE;
            end
         end
         ST_META_RD: begin
            cmd.meta_rd = 1'b1;
            state_in    = ST_META_CHK;
         end
         ST_META_CHK: begin
            if (stat.is_search) begin
               cmd.slot_clr = 1'b1;
               state_in     = ST_SLOT_RD;
            end else if (stat.next_valid) begin
               cmd.follow = 1'b1;
               state_in   = ST_META_RD;
            end else if (!stat.block_full) begin
               cmd.ins_slot   = 1'b1;
               cmd.rsp_go     = 1'b1;
               cmd.rsp_status = chbh_pkg::STAT_OK;
               state_in       = ST_IDLE;
            end else if (stat.pool_full) begin
               cmd.rsp_go     = 1'b1;
               cmd.rsp_status = chbh_pkg::STAT_FULL;
               state_in       = ST_IDLE;
            end else begin
               // last block full: point it at the block about to be taken
               cmd.link = 1'b1;
               state_in = ST_ALLOC;
            end
         end
         ST_ALLOC: begin
            cmd.alloc      = 1'b1;
            cmd.rsp_go     = 1'b1;
            cmd.rsp_status = chbh_pkg::STAT_OK;
            state_in       = ST_IDLE;
         end
         ST_SLOT_RD: begin
            cmd.slot_rd = 1'b1;
            state_in    = ST_SLOT_CHK;
         end
         ST_SLOT_CHK: begin
            if (stat.key_match) begin
               cmd.rsp_go     = 1'b1;
               cmd.rsp_hit    = 1'b1;
               cmd.rsp_status = chbh_pkg::STAT_OK;
               state_in       = ST_IDLE;
            end else if (!stat.slot_last) begin
               cmd.slot_inc = 1'b1;
               state_in     = ST_SLOT_RD;
            end else if (stat.next_valid) begin
               cmd.follow = 1'b1;
               state_in   = ST_META_RD;
            end else begin
               cmd.rsp_go     = 1'b1;
               cmd.rsp_status = chbh_pkg::STAT_MISS;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ----- rtl/chained_bucket_hash_table_unit.sv -----
// ----------------------------------------------------------------------------
// chained_bucket_hash_table_unit
// Hash table with bucket chains of fixed-size blocks from a block pool.
// ----------------------------------------------------------------------------
// An item (req_data: insert or search of a key) is taken at a clock edge with
// start high and busy low. The bucket is the key modulo BUCKETS, worked out
// four key bits a cycle. The chain is then walked through one memory read
// port at a time: each block visited is read in ST_META_RD and checked in
// ST_META_CHK, and on a search each slot compared is read in ST_SLOT_RD and
// checked in ST_SLOT_CHK. An insert that finds the last block of its chain
// full links a new block to it.
// The next item may be started in the cycle rsp_strobe is high.
// Each result sits on rsp_data for exactly one cycle with rsp_strobe high; the
// receiver must take it then.
// After reset the bucket head memory is cleared one bucket a cycle, with busy
// high until every bucket is cleared. The block pool is emptied at once by
// reset; blocks are never freed, and an insert that needs a block when all
// POOL_BLOCKS are taken answers pool full and changes nothing.
// ----------------------------------------------------------------------------
module chained_bucket_hash_table_unit #(
   parameter int BUCKETS         = 16,
   parameter int SLOTS_PER_BLOCK = 4,
   parameter int POOL_BLOCKS     = 256,
   parameter int VALUE_BITS      = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  chbh_pkg::req_type req_data,
   output logic              rsp_strobe,
   output chbh_pkg::rsp_type rsp_data
);

   chbh_pkg::ctrl_cmd_type cmd;
   chbh_pkg::dp_stat_type  stat;

   chbh_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   chbh_dp #(
      .BUCKETS         (BUCKETS),
      .SLOTS_PER_BLOCK (SLOTS_PER_BLOCK),
      .POOL_BLOCKS     (POOL_BLOCKS),
      .VALUE_BITS      (VALUE_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // one result per item, never in back-to-back cycles
   a_rsp_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe in consecutive cycles");

   // a result is only issued as the controller goes back to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result while controller busy");

   // an accepted item cannot answer in the next cycle
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_strobe)
      else $error("result one cycle after acceptance");

   // pool full is only reported when the pool really is used up
   a_full_real: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == chbh_pkg::STAT_FULL) |-> stat.pool_full)
      else $error("pool full reported with free blocks");

endmodule
